/* design/mmpb_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mmpb_pkg
// Shared types, constants and helpers of the min/max peak builder.
// ----------------------------------------------------------------------------
package mmpb_pkg;

   localparam int LEVEL_COUNT  = 4;
   localparam int MAX_CHANNELS = 2;
   localparam int SAMPLE_BITS  = 24;
   localparam int COUNT_BITS   = 17;
   localparam int INDEX_BITS   = 32;
   localparam int LEVEL_BITS   = 2;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int ADDR_BITS    = 5;
   localparam int DATA_BITS    = 32;

   localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = COUNT_BITS'(65536);

   // register indexes
   localparam logic [2:0] REG_NUM_CHANNELS = 3'd0;
   localparam logic [2:0] REG_FINE_STRIDE  = 3'd1;
   localparam logic [2:0] REG_RATIO_LEVEL1 = 3'd2;
   localparam logic [2:0] REG_RATIO_LEVEL2 = 3'd3;
   localparam logic [2:0] REG_RATIO_LEVEL3 = 3'd4;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   typedef struct packed {
      sample_type sample_ch0;
      sample_type sample_ch1;
      logic       end_of_stream;
   } req_type;

   typedef struct packed {
      logic [LEVEL_BITS-1:0] level;
      logic [INDEX_BITS-1:0] peak_index;
      sample_type            min_ch0;
      sample_type            max_ch0;
      sample_type            min_ch1;
      sample_type            max_ch1;
      logic                  last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [1:0]                                 num_channels;
      logic [COUNT_BITS-1:0]                      fine_stride;
      logic [LEVEL_COUNT-2:0][COUNT_BITS-1:0]     ratio;
   } cfg_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0] peak_index;
      sample_type            min_ch0;
      sample_type            max_ch0;
      sample_type            min_ch1;
      sample_type            max_ch1;
   } peak_type;

   typedef struct packed {
      logic [LEVEL_COUNT-1:0]           mask;
      peak_type [LEVEL_COUNT-1:0]       peaks;
   } burst_type;

   // zero acts as one, oversized values clamp to the limit
   function automatic logic [COUNT_BITS-1:0] eff_count(input logic [COUNT_BITS-1:0] v);
      logic [COUNT_BITS-1:0] r;
      if (v == '0) begin
         r = COUNT_BITS'(1);
      end else if (v > COUNT_LIMIT) begin
         r = COUNT_LIMIT;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

/* design/multilevel_min_max_peak_builder_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// multilevel_min_max_peak_builder_core
// Min/max waveform peak builder over four decimation levels.
//
// Requests are audio frames pushed on req_data while full is low. Each frame
// updates the level-0 running min/max; every fine_stride frames (or on
// end_of_stream) a level-0 peak closes and is folded into levels 1 to 3,
// which close after their configured ratio. Results pop from rsp_data while
// empty is low, in increasing level order, last_of_run marking the final
// result of a frame.
// One frame is taken per cycle while full is low. A frame that closes peaks
// pushes one burst into the queue; results leave the output register at one
// per cycle while the receiver pops, so a frame closing k levels holds a queue
// slot until its k results are loaded. The four-entry burst queue absorbs
// bursts; when it fills while the receiver stalls, full rises and intake waits.
// Reset clears all counters, running extremes and queues and loads the
// register defaults; no clearing pass is needed. The APB registers
// (num_channels, fine_stride, ratio_level1..3 at 4*i) must be written by the
// user only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module multilevel_min_max_peak_builder_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                push,
   output logic                                     full,
   input  wire mmpb_pkg::req_type                   req_data,
   output logic                                     empty,
   input  wire logic                                pop,
   output mmpb_pkg::rsp_type                        rsp_data,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [mmpb_pkg::ADDR_BITS-1:0]      paddr,
   input  wire logic [mmpb_pkg::DATA_BITS-1:0]      pwdata,
   output logic [mmpb_pkg::DATA_BITS-1:0]           prdata,
   output logic                                     pready
);

   localparam int CB = mmpb_pkg::COUNT_BITS;
   localparam int DB = mmpb_pkg::DATA_BITS;

   mmpb_pkg::cfg_type    cfg_ff, cfg_in;
   mmpb_pkg::burst_type  burst;
   mmpb_pkg::burst_type  head;
   logic                 burst_push;
   logic                 head_empty;
   logic                 head_pop;
   logic                 accept;
   logic                 wr_en;
   logic [2:0]           reg_idx;

   always_comb begin
      pready  = 1'b1;
      reg_idx = paddr[4:2];
      wr_en   = psel && penable && pwrite && pready;
      cfg_in  = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            mmpb_pkg::REG_NUM_CHANNELS: cfg_in.num_channels = pwdata[1:0];
            mmpb_pkg::REG_FINE_STRIDE:  cfg_in.fine_stride  = pwdata[CB-1:0];
            mmpb_pkg::REG_RATIO_LEVEL1: cfg_in.ratio[0]     = pwdata[CB-1:0];
            mmpb_pkg::REG_RATIO_LEVEL2: cfg_in.ratio[1]     = pwdata[CB-1:0];
            mmpb_pkg::REG_RATIO_LEVEL3: cfg_in.ratio[2]     = pwdata[CB-1:0];
            default: ;
         endcase
      end
      unique case (reg_idx)
         mmpb_pkg::REG_NUM_CHANNELS: prdata = DB'(cfg_ff.num_channels);
         mmpb_pkg::REG_FINE_STRIDE:  prdata = DB'(cfg_ff.fine_stride);
         mmpb_pkg::REG_RATIO_LEVEL1: prdata = DB'(cfg_ff.ratio[0]);
         mmpb_pkg::REG_RATIO_LEVEL2: prdata = DB'(cfg_ff.ratio[1]);
         mmpb_pkg::REG_RATIO_LEVEL3: prdata = DB'(cfg_ff.ratio[2]);
         default:                    prdata = '0;
      endcase
      accept = push && !full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.num_channels <= 2'd2;
         cfg_ff.fine_stride  <= CB'(256);
         cfg_ff.ratio[0]     <= CB'(4);
         cfg_ff.ratio[1]     <= CB'(16);
         cfg_ff.ratio[2]     <= CB'(64);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mmpb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .accept     (accept),
      .req        (req_data),
      .burst_push (burst_push),
      .burst      (burst)
   );

   mmpb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (burst_push),
      .push_data (burst),
      .pop       (head_pop),
      .full      (full),
      .empty     (head_empty),
      .head      (head)
   );

   mmpb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_empty (head_empty),
      .head       (head),
      .head_pop   (head_pop),
      .pop        (pop),
      .empty      (empty),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire

/* design/mmpb_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mmpb_front
// Frame intake: level-0 running extremes, folding into coarser levels and
// peak closing decisions. Each frame that closes a peak yields one burst.
// ----------------------------------------------------------------------------
module mmpb_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire mmpb_pkg::cfg_type   cfg,
   input  wire logic                accept,
   input  wire mmpb_pkg::req_type   req,
   output logic                     burst_push,
   output mmpb_pkg::burst_type      burst
);

   localparam int NL = mmpb_pkg::LEVEL_COUNT;
   localparam int NC = mmpb_pkg::MAX_CHANNELS;
   localparam int CB = mmpb_pkg::COUNT_BITS;

   logic [CB-1:0]                      frame_count_ff, frame_count_in;
   logic [CB-1:0]                      group_count_ff [1:NL-1];
   logic [CB-1:0]                      group_count_in [1:NL-1];
   mmpb_pkg::sample_type               run_min_ff [NL][NC];
   mmpb_pkg::sample_type               run_max_ff [NL][NC];
   mmpb_pkg::sample_type               run_min_in [NL][NC];
   mmpb_pkg::sample_type               run_max_in [NL][NC];
   logic [mmpb_pkg::INDEX_BITS-1:0]    peak_count_ff [NL];
   logic [mmpb_pkg::INDEX_BITS-1:0]    peak_count_in [NL];

   mmpb_pkg::sample_type  smp [NC];
   logic                  two_ch;
   logic                  act [NC];
   logic [CB-1:0]         fc_inc;
   logic [CB-1:0]         gc_inc;
   logic [NL-1:0]         close;

   always_comb begin
      smp[0]        = req.sample_ch0;
      smp[NC-1]     = req.sample_ch1;
      two_ch        = (cfg.num_channels >= 2'd2) && (NC >= 2);
      for (int c = 0; c < NC; c++) begin
         act[c] = (c == 0) || two_ch;
      end

      run_min_in = run_min_ff;
      run_max_in = run_max_ff;
      for (int c = 0; c < NC; c++) begin
         if (act[c] && (frame_count_ff == '0 || smp[c] < run_min_ff[0][c])) begin
            run_min_in[0][c] = smp[c];
         end
         if (act[c] && (frame_count_ff == '0 || smp[c] > run_max_ff[0][c])) begin
            run_max_in[0][c] = smp[c];
         end
      end

      fc_inc   = (frame_count_ff < mmpb_pkg::COUNT_LIMIT) ? frame_count_ff + CB'(1)
                                                          : frame_count_ff;
      close    = '0;
      close[0] = (fc_inc >= mmpb_pkg::eff_count(cfg.fine_stride)) || req.end_of_stream;
      frame_count_in = close[0] ? '0 : fc_inc;

      for (int l = 1; l < NL; l++) begin
         group_count_in[l] = group_count_ff[l];
         gc_inc = (group_count_ff[l] < mmpb_pkg::COUNT_LIMIT)
                  ? group_count_ff[l] + CB'(1) : group_count_ff[l];
         if (close[0]) begin
            for (int c = 0; c < NC; c++) begin
               if (act[c] && (group_count_ff[l] == '0 ||
                              run_min_in[0][c] < run_min_ff[l][c])) begin
                  run_min_in[l][c] = run_min_in[0][c];
               end
               if (act[c] && (group_count_ff[l] == '0 ||
                              run_max_in[0][c] > run_max_ff[l][c])) begin
                  run_max_in[l][c] = run_max_in[0][c];
               end
            end
            close[l] = (gc_inc >= mmpb_pkg::eff_count(cfg.ratio[l-1])) ||
                       req.end_of_stream;
            group_count_in[l] = close[l] ? '0 : gc_inc;
         end
      end

      burst.mask = close;
      for (int l = 0; l < NL; l++) begin
         burst.peaks[l].peak_index = peak_count_ff[l];
         burst.peaks[l].min_ch0    = run_min_in[l][0];
         burst.peaks[l].max_ch0    = run_max_in[l][0];
         burst.peaks[l].min_ch1    = two_ch ? run_min_in[l][NC-1] : '0;
         burst.peaks[l].max_ch1    = two_ch ? run_max_in[l][NC-1] : '0;
         if (req.end_of_stream) begin
            peak_count_in[l] = '0;
         end else if (close[l]) begin
            peak_count_in[l] = peak_count_ff[l] + mmpb_pkg::INDEX_BITS'(1);
         end else begin
            peak_count_in[l] = peak_count_ff[l];
         end
      end
      burst_push = accept && close[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= '0;
         for (int l = 1; l < NL; l++) begin
            group_count_ff[l] <= '0;
         end
         for (int l = 0; l < NL; l++) begin
            peak_count_ff[l] <= '0;
            for (int c = 0; c < NC; c++) begin
               run_min_ff[l][c] <= '0;
               run_max_ff[l][c] <= '0;
            end
         end
      end else if (accept) begin
         frame_count_ff <= frame_count_in;
         group_count_ff <= group_count_in;
         peak_count_ff  <= peak_count_in;
         run_min_ff     <= run_min_in;
         run_max_ff     <= run_max_in;
      end
   end

endmodule
`default_nettype wire

/* design/mmpb_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mmpb_queue
// Short burst queue between frame intake and result serializer.
// ----------------------------------------------------------------------------
module mmpb_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire mmpb_pkg::burst_type  push_data,
   input  wire logic                 pop,
   output logic                      full,
   output logic                      empty,
   output mmpb_pkg::burst_type       head
);

   localparam int PB = mmpb_pkg::QPTR_BITS;

   mmpb_pkg::burst_type  mem_ff [mmpb_pkg::QUEUE_DEPTH];
   logic [PB-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PB-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [PB:0]          count_ff, count_in;
   logic                 do_push, do_pop;

   always_comb begin
      full      = (count_ff == (PB+1)'(mmpb_pkg::QUEUE_DEPTH));
      empty     = (count_ff == '0);
      head      = mem_ff[rd_ptr_ff];
      do_push   = push && !full;
      do_pop    = pop && !empty;
      wr_ptr_in = do_push ? wr_ptr_ff + PB'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PB'(1) : rd_ptr_ff;
      count_in  = count_ff + (PB+1)'(do_push) - (PB+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

/* design/mmpb_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mmpb_back
// Result serializer: walks the levels of the head burst in increasing order
// and feeds one result per cycle into the free or popped output register.
// ----------------------------------------------------------------------------
module mmpb_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 head_empty,
   input  wire mmpb_pkg::burst_type  head,
   output logic                      head_pop,
   input  wire logic                 pop,
   output logic                      empty,
   output mmpb_pkg::rsp_type         rsp_data
);

   localparam int NL = mmpb_pkg::LEVEL_COUNT;

   logic [NL-1:0]                     done_ff, done_in;
   logic                              out_valid_ff, out_valid_in;
   mmpb_pkg::rsp_type                 out_ff, out_in;
   logic [NL-1:0]                     rem;
   logic [NL-1:0]                     sel_bit;
   logic [mmpb_pkg::LEVEL_BITS-1:0]   sel;
   logic                              load;
   logic                              last;

   always_comb begin
      rem     = head.mask & ~done_ff;
      sel     = '0;
      sel_bit = '0;
      for (int l = NL-1; l >= 0; l--) begin
         if (rem[l]) begin
            sel     = mmpb_pkg::LEVEL_BITS'(l);
            sel_bit = NL'(1) << l;
         end
      end
      last     = ((rem & ~sel_bit) == '0);
      load     = !head_empty && (!out_valid_ff || pop);
      head_pop = load && last;

      done_in = done_ff;
      if (load) begin
         done_in = last ? '0 : (done_ff | sel_bit);
      end

      out_valid_in = load ? 1'b1 : (pop ? 1'b0 : out_valid_ff);
      out_in             = out_ff;
      if (load) begin
         out_in.level       = sel;
         out_in.peak_index  = head.peaks[sel].peak_index;
         out_in.min_ch0     = head.peaks[sel].min_ch0;
         out_in.max_ch0     = head.peaks[sel].max_ch0;
         out_in.min_ch1     = head.peaks[sel].min_ch1;
         out_in.max_ch1     = head.peaks[sel].max_ch1;
         out_in.last_of_run = last;
      end

      empty    = !out_valid_ff;
      rsp_data = out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         done_ff      <= done_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   // every burst carries a level-0 peak
   a_level0_present: assert property (@(posedge clock) disable iff (reset)
      !head_empty |-> head.mask[0])
      else $error("burst without level-0 peak");

   // progress marks stay within the head burst
   a_done_subset: assert property (@(posedge clock) disable iff (reset)
      head_empty ? (done_ff == '0) : ((done_ff & ~head.mask) == '0))
      else $error("serializer progress outside head burst");

   // a non-final result is followed at once by a higher level of the same frame
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && pop && !out_ff.last_of_run |=>
         out_valid_ff && (out_ff.level > $past(out_ff.level)))
      else $error("run of results broken");

endmodule
`default_nettype wire

/* tb/tb_multilevel_min_max_peak_builder_core.sv */
// ----------------------------------------------------------------------------
// tb_multilevel_min_max_peak_builder_core
// Self-checking bench for the four-level min/max peak builder.
//
// A short directed script covers sample extremes, one-channel modes, zero and
// oversized strides and ratios, a stride change inside an open peak, unused
// register addresses and end-of-stream flushes. Eight random phases follow,
// each with its own register setting and one of four mixes of request gaps
// and result stalls. Every accepted frame goes through a local predictor of
// the peak builder, and each popped result is compared field by field against
// the oldest pending expected peak, predicted or given by the script.
// ----------------------------------------------------------------------------
module tb_multilevel_min_max_peak_builder_core;

   localparam logic [2:0] REG_SPARE_LO = 3'd5;
   localparam logic [2:0] REG_SPARE_HI = 3'd7;
   localparam logic [16:0] SPAN_LIMIT = 17'h10000;
   localparam int SETTLE_CYCLES = 8;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASES = 8;
   localparam int FRAMES_PER_PHASE = 52;
   localparam int REPORT_LIMIT = 10;

   typedef enum logic {ROW_WRITE, ROW_FRAME} row_kind_type;

   typedef struct {
      row_kind_type        kind;
      logic [2:0]          reg_idx;
      logic [31:0]         value;
      mmpb_pkg::req_type   req;
      bit                  typed;
      mmpb_pkg::rsp_type   exp;
   } script_row_type;

   logic              clock;
   logic              reset = 1'b1;
   logic              push = 1'b0;
   logic              full;
   mmpb_pkg::req_type req_data = '0;
   logic              empty;
   logic              pop = 1'b0;
   mmpb_pkg::rsp_type rsp_data;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [mmpb_pkg::ADDR_BITS-1:0] paddr = '0;
   logic [mmpb_pkg::DATA_BITS-1:0] pwdata = '0;
   logic [mmpb_pkg::DATA_BITS-1:0] prdata;
   logic              pready;

   // predictor state
   logic [1:0]  cfg_channels;
   logic [16:0] cfg_stride;
   logic [16:0] cfg_ratio [1:3];
   logic [16:0] frames_in_peak;
   logic [16:0] folds_in_peak [1:3];
   mmpb_pkg::sample_type lo_mark [0:3][0:1];
   mmpb_pkg::sample_type hi_mark [0:3][0:1];
   logic [31:0] next_index [0:3];
   mmpb_pkg::rsp_type fresh [0:3];

   script_row_type    script [$];
   script_row_type    outgoing [$];
   mmpb_pkg::rsp_type pending_peaks [$];

   int errors = 0;
   int frames_taken = 0;
   int peaks_seen = 0;
   int settings_written = 0;
   int stalled_cycles = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;

   multilevel_min_max_peak_builder_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [16:0] span_of(input logic [16:0] v);
      if (v == '0) begin
         return 17'd1;
      end else if (v > SPAN_LIMIT) begin
         return SPAN_LIMIT;
      end
      return v;
   endfunction

   function automatic mmpb_pkg::rsp_type close_peak(input int lvl, input bit two);
      mmpb_pkg::rsp_type p;
      p.level       = lvl[1:0];
      p.peak_index  = next_index[lvl];
      p.min_ch0     = lo_mark[lvl][0];
      p.max_ch0     = hi_mark[lvl][0];
      p.min_ch1     = two ? lo_mark[lvl][1] : '0;
      p.max_ch1     = two ? hi_mark[lvl][1] : '0;
      p.last_of_run = 1'b0;
      next_index[lvl] = next_index[lvl] + 32'd1;
      return p;
   endfunction

   task automatic predict_frame(input mmpb_pkg::req_type r, output int n);
      bit                   two;
      int                   nch;
      mmpb_pkg::sample_type s [0:1];
      two = (cfg_channels >= 2'd2);
      nch = two ? 2 : 1;
      s[0] = r.sample_ch0;
      s[1] = r.sample_ch1;
      n = 0;
      for (int ch = 0; ch < nch; ch++) begin
         if (frames_in_peak == '0 || s[ch] < lo_mark[0][ch]) lo_mark[0][ch] = s[ch];
         if (frames_in_peak == '0 || s[ch] > hi_mark[0][ch]) hi_mark[0][ch] = s[ch];
      end
      if (frames_in_peak < SPAN_LIMIT) frames_in_peak = frames_in_peak + 17'd1;
      if (frames_in_peak >= span_of(cfg_stride) || r.end_of_stream) begin
         frames_in_peak = '0;
         fresh[n] = close_peak(0, two);
         n++;
         for (int lvl = 1; lvl < 4; lvl++) begin
            for (int ch = 0; ch < nch; ch++) begin
               if (folds_in_peak[lvl] == '0 || lo_mark[0][ch] < lo_mark[lvl][ch])
                  lo_mark[lvl][ch] = lo_mark[0][ch];
               if (folds_in_peak[lvl] == '0 || hi_mark[0][ch] > hi_mark[lvl][ch])
                  hi_mark[lvl][ch] = hi_mark[0][ch];
            end
            if (folds_in_peak[lvl] < SPAN_LIMIT)
               folds_in_peak[lvl] = folds_in_peak[lvl] + 17'd1;
            if (folds_in_peak[lvl] >= span_of(cfg_ratio[lvl]) || r.end_of_stream) begin
               folds_in_peak[lvl] = '0;
               fresh[n] = close_peak(lvl, two);
               n++;
            end
         end
      end
      if (r.end_of_stream) begin
         frames_in_peak = '0;
         for (int lvl = 1; lvl < 4; lvl++) folds_in_peak[lvl] = '0;
         for (int lvl = 0; lvl < 4; lvl++) next_index[lvl] = '0;
      end
      if (n > 0) fresh[n-1].last_of_run = 1'b1;
   endtask

   task automatic flag(input string msg);
      errors++;
      if (errors <= REPORT_LIMIT) $display("MISMATCH at %0t: %s", $time, msg);
   endtask

   task automatic check_field(input string what, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) flag($sformatf("%s expected %h got %h", what, want, got));
   endtask

   // checks the request stream and the result stream, runs the watchdog
   always @(posedge clock) begin : scoreboard
      script_row_type    fe;
      mmpb_pkg::rsp_type want;
      int                n;
      bit                took;
      if (!reset) begin
         took = 1'b0;
         if (push && !full) begin
            took = 1'b1;
            fe = outgoing.pop_front();
            predict_frame(fe.req, n);
            if (fe.typed) begin
               pending_peaks.push_back(fe.exp);
            end else begin
               for (int i = 0; i < n; i++) pending_peaks.push_back(fresh[i]);
            end
            frames_taken++;
         end
         if (pop && !empty) begin
            took = 1'b1;
            peaks_seen++;
            if (pending_peaks.size() == 0) begin
               flag("result with no peak pending");
            end else begin
               want = pending_peaks.pop_front();
               check_field("level", 64'(want.level), 64'(rsp_data.level));
               check_field("peak_index", 64'(want.peak_index), 64'(rsp_data.peak_index));
               check_field("min_ch0", 64'(want.min_ch0), 64'(rsp_data.min_ch0));
               check_field("max_ch0", 64'(want.max_ch0), 64'(rsp_data.max_ch0));
               check_field("min_ch1", 64'(want.min_ch1), 64'(rsp_data.min_ch1));
               check_field("max_ch1", 64'(want.max_ch1), 64'(rsp_data.max_ch1));
               check_field("last_of_run", 64'(want.last_of_run), 64'(rsp_data.last_of_run));
            end
         end
         stalled_cycles = took ? 0 : stalled_cycles + 1;
         if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   always @(posedge clock) begin
      pop <= !reset && ($urandom_range(99) >= stall_pct);
   end

   function automatic mmpb_pkg::req_type frame_of(input int ch0, input int ch1,
                                                  input bit eos);
      mmpb_pkg::req_type r;
      r.sample_ch0    = mmpb_pkg::sample_type'(ch0);
      r.sample_ch1    = mmpb_pkg::sample_type'(ch1);
      r.end_of_stream = eos;
      return r;
   endfunction

   function automatic mmpb_pkg::rsp_type peak(input int lvl, input int idx, input int mn0,
                                              input int mx0, input int mn1, input int mx1);
      mmpb_pkg::rsp_type p;
      p.level       = lvl[1:0];
      p.peak_index  = idx;
      p.min_ch0     = mmpb_pkg::sample_type'(mn0);
      p.max_ch0     = mmpb_pkg::sample_type'(mx0);
      p.min_ch1     = mmpb_pkg::sample_type'(mn1);
      p.max_ch1     = mmpb_pkg::sample_type'(mx1);
      p.last_of_run = 1'b1;
      return p;
   endfunction

   task automatic table_write(input logic [2:0] reg_idx, input logic [31:0] value);
      script_row_type row;
      row = '{kind: ROW_WRITE, reg_idx: reg_idx, value: value, req: '0, typed: 1'b0,
              exp: '0};
      script.push_back(row);
   endtask

   task automatic table_frame(input int ch0, input int ch1, input bit eos);
      script_row_type row;
      row = '{kind: ROW_FRAME, reg_idx: '0, value: '0, req: frame_of(ch0, ch1, eos),
              typed: 1'b0, exp: '0};
      script.push_back(row);
   endtask

   task automatic table_typed(input int ch0, input int ch1, input mmpb_pkg::rsp_type exp);
      script_row_type row;
      row = '{kind: ROW_FRAME, reg_idx: '0, value: '0, req: frame_of(ch0, ch1, 1'b0),
              typed: 1'b1, exp: exp};
      script.push_back(row);
   endtask

   function automatic mmpb_pkg::sample_type pick_sample();
      case ($urandom_range(15))
         0: return mmpb_pkg::sample_type'(24'h7FFFFF);
         1: return mmpb_pkg::sample_type'(24'h800000);
         2: return '0;
         3: return '1;
         default: return mmpb_pkg::sample_type'($urandom);
      endcase
   endfunction

   task automatic send_frame(input mmpb_pkg::req_type r, input bit typed,
                             input mmpb_pkg::rsp_type exp);
      script_row_type row;
      row = '{kind: ROW_FRAME, reg_idx: '0, value: '0, req: r, typed: typed, exp: exp};
      outgoing.push_back(row);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push     <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (full) @(posedge clock);
   endtask

   task automatic wait_idle();
      push <= 1'b0;
      @(posedge clock);
      while (pending_peaks.size() != 0 || outgoing.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_cycle(input logic [2:0] reg_idx, input bit wr,
                            input logic [31:0] value, output logic [31:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {reg_idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_register(input logic [2:0] reg_idx, input logic [31:0] value);
      logic [31:0] rdata;
      logic [31:0] held;
      bit          known;
      known = 1'b1;
      csr_cycle(reg_idx, 1'b1, value, rdata);
      settings_written++;
      case (reg_idx)
         mmpb_pkg::REG_NUM_CHANNELS: begin
            cfg_channels = value[1:0];
            held = 32'(value[1:0]);
         end
         mmpb_pkg::REG_FINE_STRIDE: begin
            cfg_stride = value[16:0];
            held = 32'(value[16:0]);
         end
         mmpb_pkg::REG_RATIO_LEVEL1: begin
            cfg_ratio[1] = value[16:0];
            held = 32'(value[16:0]);
         end
         mmpb_pkg::REG_RATIO_LEVEL2: begin
            cfg_ratio[2] = value[16:0];
            held = 32'(value[16:0]);
         end
         mmpb_pkg::REG_RATIO_LEVEL3: begin
            cfg_ratio[3] = value[16:0];
            held = 32'(value[16:0]);
         end
         default: begin
            known = 1'b0;
            held = '0;
         end
      endcase
      if (known) begin
         csr_cycle(reg_idx, 1'b0, '0, rdata);
         check_field($sformatf("readback of register %0d", reg_idx), 64'(held), 64'(rdata));
      end
   endtask

   function automatic logic [31:0] with_junk(input logic [31:0] v, input logic [31:0] mask);
      return ($urandom & ~mask) | (v & mask);
   endfunction

   initial begin
      logic [31:0]       ch, st, r1, r2, r3;
      int                eos_odds;
      mmpb_pkg::req_type r;

      cfg_channels = 2'd2;
      cfg_stride   = 17'd256;
      cfg_ratio[1] = 17'd4;
      cfg_ratio[2] = 17'd16;
      cfg_ratio[3] = 17'd64;
      frames_in_peak = '0;
      for (int lvl = 0; lvl < 4; lvl++) begin
         next_index[lvl] = '0;
         if (lvl > 0) folds_in_peak[lvl] = '0;
         for (int c = 0; c < 2; c++) begin
            lo_mark[lvl][c] = '0;
            hi_mark[lvl][c] = '0;
         end
      end

      // directed script
      table_frame(123456, -654321, 1'b1);
      table_write(mmpb_pkg::REG_FINE_STRIDE, 32'd1);
      table_typed(8388607, -8388608, peak(0, 0, 8388607, 8388607, -8388608, -8388608));
      table_typed(-8388608, 8388607, peak(0, 1, -8388608, -8388608, 8388607, 8388607));
      table_typed(0, 0, peak(0, 2, 0, 0, 0, 0));
      table_frame(-1, 1, 1'b0);
      table_frame(5, -5, 1'b1);
      table_write(mmpb_pkg::REG_NUM_CHANNELS, 32'd1);
      table_typed(100, 200, peak(0, 0, 100, 100, 0, 0));
      table_write(mmpb_pkg::REG_NUM_CHANNELS, 32'd0);
      table_typed(-7, 3, peak(0, 1, -7, -7, 0, 0));
      table_write(mmpb_pkg::REG_NUM_CHANNELS, 32'd3);
      table_frame(9, -9, 1'b0);
      table_write(mmpb_pkg::REG_FINE_STRIDE, 32'd0);
      table_frame(42, -42, 1'b0);
      table_write(mmpb_pkg::REG_RATIO_LEVEL1, 32'd0);
      table_write(mmpb_pkg::REG_RATIO_LEVEL2, 32'd1);
      table_write(mmpb_pkg::REG_RATIO_LEVEL3, 32'd2);
      table_frame(1000, -1000, 1'b0);
      table_frame(-2000, 2000, 1'b0);
      table_write(mmpb_pkg::REG_FINE_STRIDE, 32'd3);
      table_frame(7, 7, 1'b0);
      table_frame(-7, -7, 1'b0);
      table_write(mmpb_pkg::REG_FINE_STRIDE, 32'd1);
      table_frame(3, 4, 1'b0);
      table_write(REG_SPARE_LO, 32'hFFFF_FFFF);
      table_write(REG_SPARE_HI, 32'd0);
      table_write(mmpb_pkg::REG_FINE_STRIDE, 32'h1FFFF);
      table_write(mmpb_pkg::REG_RATIO_LEVEL1, 32'h1FFFF);
      table_write(mmpb_pkg::REG_RATIO_LEVEL2, 32'h10000);
      table_write(mmpb_pkg::REG_RATIO_LEVEL3, 32'h1FFFF);
      table_frame(-300, 300, 1'b0);
      table_frame(600, -600, 1'b1);
      table_write(mmpb_pkg::REG_NUM_CHANNELS, 32'd2);
      table_frame(8388607, 8388607, 1'b1);
      table_frame(-8388608, -8388608, 1'b1);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[i]) begin
         if (script[i].kind == ROW_WRITE) begin
            wait_idle();
            set_register(script[i].reg_idx, script[i].value);
         end else begin
            send_frame(script[i].req, script[i].typed, script[i].exp);
         end
      end

      // random phases
      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         eos_odds = 30;
         if (p == 3) begin
            ch = 2; st = 1; r1 = 1; r2 = 1; r3 = 1;
         end else if (p == 6) begin
            ch = $urandom_range(0, 3);
            st = 32'h1FFFF; r1 = 32'h10000; r2 = 32'h1FFFF; r3 = 32'h1FFFF;
            eos_odds = 10;
         end else begin
            ch = $urandom_range(0, 3);
            st = $urandom_range(0, 5);
            r1 = $urandom_range(0, 4);
            r2 = $urandom_range(0, 9);
            r3 = $urandom_range(0, 17);
         end
         set_register(mmpb_pkg::REG_NUM_CHANNELS, with_junk(ch, 32'h3));
         set_register(mmpb_pkg::REG_FINE_STRIDE, with_junk(st, 32'h1FFFF));
         set_register(mmpb_pkg::REG_RATIO_LEVEL1, with_junk(r1, 32'h1FFFF));
         set_register(mmpb_pkg::REG_RATIO_LEVEL2, with_junk(r2, 32'h1FFFF));
         set_register(mmpb_pkg::REG_RATIO_LEVEL3, with_junk(r3, 32'h1FFFF));
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 57; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 57; end
            default: begin send_idle_pct = 21; stall_pct = 21; end
         endcase
         repeat (FRAMES_PER_PHASE) begin
            r.sample_ch0    = pick_sample();
            r.sample_ch1    = pick_sample();
            r.end_of_stream = ($urandom_range(eos_odds - 1) == 0);
            send_frame(r, 1'b0, '0);
         end
      end
      wait_idle();

      $display("covered %0d frames, %0d peaks checked, %0d register writes",
               frames_taken, peaks_seen, settings_written);
      $display("%0d mismatches counted", errors);
      if (errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
